/* hdl/bic_pkg.sv */
// Package for the barometer integer compensation core.
// Holds field widths, register indexes, fixed constants and shift and sign-extension helpers.
// No dependencies.
package bic_pkg;

  localparam int RAW_T_W = 16;
  localparam int RAW_P_W = 19;
  localparam int TEMP_W  = 16;
  localparam int PRESS_W = 18;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OSS   = 2'd0;
  localparam logic [1:0] REG_CAL_A = 2'd1;
  localparam logic [1:0] REG_CAL_B = 2'd2;
  localparam logic [1:0] REG_CAL_C = 2'd3;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] P_K1      = 32'd3038;
  localparam logic [31:0] P_K2      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_K3      = 32'd3791;

  localparam logic [31:0] PRESS_MAX = 32'd262143;

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
    asr32 = $unsigned($signed(v) >>> n);
  endfunction

  // Sign extension of a 16-bit coefficient.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

/* hdl/bic_if.sv */
// Stream interfaces for the input and result channels.
// Depends on bic_pkg for the field widths.
interface bic_in_if;
  import bic_pkg::*;
  logic               valid;
  logic               ready;
  logic [RAW_T_W-1:0] raw_temperature;
  logic [RAW_P_W-1:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bic_out_if;
  import bic_pkg::*;
  logic               valid;
  logic               ready;
  logic [TEMP_W-1:0]  temperature_tenths;
  logic [PRESS_W-1:0] pressure_pa;
  logic               divide_error;
  modport source (output valid, temperature_tenths, pressure_pa, divide_error,
                  input ready);
  modport sink   (input valid, temperature_tenths, pressure_pa, divide_error,
                  output ready);
endinterface

/* hdl/bic_udiv.sv */
// Pipelined unsigned divider, one quotient bit per stage, with sideband data.
// Standalone; used by barometer_integer_compensation_core.
module bic_udiv #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quo,
  output logic [SW-1:0] side_out
);

  logic          v_r    [0:W-1];
  logic [W-1:0]  num_r  [0:W-1];
  logic [W-1:0]  den_r  [0:W-1];
  logic [W-1:0]  rem_r  [0:W-1];
  logic [W-1:0]  q_r    [0:W-1];
  logic [SW-1:0] side_r [0:W-1];

  logic [W-1:0] num_in  [0:W-1];
  logic [W-1:0] den_in  [0:W-1];
  logic [W-1:0] rem_in  [0:W-1];
  logic [W-1:0] q_in    [0:W-1];
  logic [W-1:0] rem_nxt [0:W-1];
  logic [W-1:0] q_nxt   [0:W-1];

  // Stage k decides quotient bit W-1-k by one compare and subtract.
  always_comb begin
    for (int k = 0; k < W; k++) begin
      logic [W:0] trial;
      logic [W:0] diff;
      num_in[k] = (k == 0) ? num : num_r[(k == 0) ? 0 : k-1];
      den_in[k] = (k == 0) ? den : den_r[(k == 0) ? 0 : k-1];
      rem_in[k] = (k == 0) ? '0  : rem_r[(k == 0) ? 0 : k-1];
      q_in[k]   = (k == 0) ? '0  : q_r[(k == 0) ? 0 : k-1];
      trial = {rem_in[k], num_in[k][W-1-k]};
      diff  = trial - {1'b0, den_in[k]};
      q_nxt[k] = q_in[k];
      if (!diff[W]) begin
        rem_nxt[k]        = diff[W-1:0];
        q_nxt[k][W-1-k]   = 1'b1;
      end else begin
        rem_nxt[k] = trial[W-1:0];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < W; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < W; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        num_r[k]  <= num_in[k];
        den_r[k]  <= den_in[k];
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        side_r[k] <= (k == 0) ? side_in : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign quo       = q_r[W-1];
  assign side_out  = side_r[W-1];

endmodule

/* hdl/barometer_integer_compensation_core.sv */
// Top level of the barometer integer compensation core.
// Depends on bic_pkg, bic_if (bic_in_if, bic_out_if) and bic_udiv.
//
//   Channel  | Kind            | Payload
//   in_if    | valid/ready     | raw_temperature, raw_pressure
//   out_if   | valid/ready     | temperature_tenths, pressure_pa, divide_error
//   cfg_*    | APB write/read  | oversampling, cal_word_a/b/c at 8*i
//
// One request enters per cycle unless stalled; the path is 12 arithmetic stages,
// two 32-stage dividers (one quotient bit per stage) and the output register.
// Reset clears all valid bits and the configuration registers.
// When the output register holds a result that is not taken, the whole
// pipeline freezes and in_if.ready drops; nothing is lost or repeated.
module barometer_integer_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  bic_in_if.sink      in_if,
  bic_out_if.source   out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import bic_pkg::*;

  // Configuration registers.
  logic [1:0]  oss_r;
  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r   <= '0;
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OSS:   oss_r   <= cfg_pwdata[1:0];
        REG_CAL_A: cal_a_r <= cfg_pwdata;
        REG_CAL_B: cal_b_r <= cfg_pwdata;
        REG_CAL_C: cal_c_r <= cfg_pwdata[31:0];
        default:   oss_r   <= oss_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OSS:   cfg_prdata = {62'd0, oss_r};
      REG_CAL_A: cfg_prdata = cal_a_r;
      REG_CAL_B: cfg_prdata = cal_b_r;
      REG_CAL_C: cfg_prdata = {32'd0, cal_c_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Calibration coefficients.
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1c, b2c, mc, md, b7_fac;
  assign ac1 = sx16(cal_a_r[15:0]);
  assign ac2 = sx16(cal_a_r[31:16]);
  assign ac3 = sx16(cal_a_r[47:32]);
  assign ac4 = {16'd0, cal_a_r[63:48]};
  assign ac5 = {16'd0, cal_b_r[15:0]};
  assign ac6 = {16'd0, cal_b_r[31:16]};
  assign b1c = sx16(cal_b_r[47:32]);
  assign b2c = sx16(cal_b_r[63:48]);
  assign mc  = sx16(cal_c_r[15:0]);
  assign md  = sx16(cal_c_r[31:16]);
  assign b7_fac = B7_SCALE >> oss_r;

  // Global advance: the pipeline moves unless the output result is stuck.
  logic out_valid_r, en;
  assign en          = !(out_valid_r && !out_if.ready);
  assign in_if.ready = en;

  // Stage 1: (ut - ac6) * ac5.
  logic        s1_v_r;
  logic [31:0] m1_r;
  logic [18:0] up1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= ({16'd0, in_if.raw_temperature} - ac6) * ac5;
      up1_r <= in_if.raw_pressure;
    end
  end

  // Stage 2: x1, divisor x1 + md, sign and magnitudes for the first division.
  logic        s2_v_r, neg2_r, dz2_r;
  logic [31:0] x1_2_r, ma2_r, mb2_r;
  logic [18:0] up2_r;
  logic [31:0] x1_s2, d_s2, n_s2;
  always_comb begin
    x1_s2 = asr32(m1_r, 15);
    d_s2  = x1_s2 + md;
    n_s2  = mc << 11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1_2_r <= x1_s2;
      ma2_r  <= n_s2[31] ? (32'd0 - n_s2) : n_s2;
      mb2_r  <= d_s2[31] ? (32'd0 - d_s2) : d_s2;
      neg2_r <= n_s2[31] ^ d_s2[31];
      dz2_r  <= (d_s2 == 32'd0);
      up2_r  <= up1_r;
    end
  end

  // First division: (mc << 11) / (x1 + md).
  localparam int SW1 = 32 + 19 + 2;
  logic           d1_v;
  logic [31:0]    d1_q;
  logic [SW1-1:0] d1_side;
  bic_udiv #(.W(32), .SW(SW1)) u_div_t (
    .clk, .rst_n, .en,
    .in_valid (s2_v_r),
    .num      (ma2_r),
    .den      (mb2_r),
    .side_in  ({x1_2_r, up2_r, neg2_r, dz2_r}),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_side)
  );

  // Stage 3: b5.
  logic        s3_v_r, e3_r;
  logic [31:0] b5_3_r;
  logic [18:0] up3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      b5_3_r <= d1_side[SW1-1 -: 32] + (d1_side[1] ? (32'd0 - d1_q) : d1_q);
      up3_r  <= d1_side[20:2];
      e3_r   <= d1_side[0];
    end
  end

  // Stage 4: temperature, b6 and products with b6.
  logic        s4_v_r, e4_r;
  logic [15:0] t4_r;
  logic [31:0] msq4_r, ma2p4_r, ma3p4_r;
  logic [18:0] up4_r;
  logic [31:0] t_s4, b6_s4;
  logic [15:0] tsat_s4;
  always_comb begin
    t_s4  = asr32(b5_3_r + 32'd8, 4);
    b6_s4 = b5_3_r - B6_OFFSET;
    if ($signed(t_s4) > 32'sd32767)       tsat_s4 = 16'h7FFF;
    else if ($signed(t_s4) < -32'sd32768) tsat_s4 = 16'h8000;
    else                                  tsat_s4 = t_s4[15:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t4_r    <= tsat_s4;
      msq4_r  <= b6_s4 * b6_s4;
      ma2p4_r <= ac2 * b6_s4;
      ma3p4_r <= ac3 * b6_s4;
      up4_r   <= up3_r;
      e4_r    <= e3_r;
    end
  end

  // Stage 5: products with the squared term.
  logic        s5_v_r, e5_r;
  logic [15:0] t5_r;
  logic [31:0] mb2p5_r, mb1p5_r, x2a5_r, x1c5_r;
  logic [18:0] up5_r;
  logic [31:0] sq_s5;
  assign sq_s5 = asr32(msq4_r, 12);
  always_ff @(posedge clk) begin
    if (en) begin
      mb2p5_r <= b2c * sq_s5;
      mb1p5_r <= b1c * sq_s5;
      x2a5_r  <= asr32(ma2p4_r, 11);
      x1c5_r  <= asr32(ma3p4_r, 13);
      t5_r    <= t4_r;
      up5_r   <= up4_r;
      e5_r    <= e4_r;
    end
  end

  // Stage 6: b3 and the b4 multiplicand.
  logic        s6_v_r, e6_r;
  logic [15:0] t6_r;
  logic [31:0] b3_6_r, ts6_r;
  logic [18:0] up6_r;
  logic [31:0] x3_s6, b3_s6, x3b_s6;
  always_comb begin
    x3_s6  = asr32(mb2p5_r, 11) + x2a5_r;
    b3_s6  = asr32((((ac1 << 2) + x3_s6) << oss_r) + 32'd2, 2);
    x3b_s6 = asr32(x1c5_r + asr32(mb1p5_r, 16) + 32'd2, 2);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b3_6_r <= b3_s6;
      ts6_r  <= x3b_s6 + B4_BIAS;
      t6_r   <= t5_r;
      up6_r  <= up5_r;
      e6_r   <= e5_r;
    end
  end

  // Stage 7: ac4 product and up - b3.
  logic        s7_v_r, e7_r;
  logic [15:0] t7_r;
  logic [31:0] mb4_7_r, diff7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mb4_7_r <= ac4 * ts6_r;
      diff7_r <= {13'd0, up6_r} - b3_6_r;
      t7_r    <= t6_r;
      e7_r    <= e6_r;
    end
  end

  // Stage 8: b4 and b7.
  logic        s8_v_r, e8_r;
  logic [15:0] t8_r;
  logic [31:0] b4_8_r, b7_8_r, b4_s8;
  assign b4_s8 = mb4_7_r >> 15;
  always_ff @(posedge clk) begin
    if (en) begin
      b4_8_r <= b4_s8;
      b7_8_r <= diff7_r * b7_fac;
      t8_r   <= t7_r;
      e8_r   <= e7_r || (b4_s8 == 32'd0);
    end
  end

  // Stage 9: dividend of the two-path division.
  logic        s9_v_r, e9_r, sh9_r;
  logic [15:0] t9_r;
  logic [31:0] num9_r, den9_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sh9_r  <= (b7_8_r >= SIGN_BIT);
      num9_r <= (b7_8_r < SIGN_BIT) ? (b7_8_r << 1) : b7_8_r;
      den9_r <= b4_8_r;
      t9_r   <= t8_r;
      e9_r   <= e8_r;
    end
  end

  // Second division: b7 path over b4.
  localparam int SW2 = 16 + 2;
  logic           d2_v;
  logic [31:0]    d2_q;
  logic [SW2-1:0] d2_side;
  bic_udiv #(.W(32), .SW(SW2)) u_div_p (
    .clk, .rst_n, .en,
    .in_valid (s9_v_r),
    .num      (num9_r),
    .den      (den9_r),
    .side_in  ({t9_r, e9_r, sh9_r}),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_side)
  );

  // Stage 10: raw pressure p.
  logic        s10_v_r, e10_r;
  logic [15:0] t10_r;
  logic [31:0] p10_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p10_r <= d2_side[0] ? (d2_q << 1) : d2_q;
      e10_r <= d2_side[1];
      t10_r <= d2_side[SW2-1 -: 16];
    end
  end

  // Stage 11: squared term and linear correction product.
  logic        s11_v_r, e11_r;
  logic [15:0] t11_r;
  logic [31:0] p11_r, mm11_r, mx11_r, ps8_s11;
  assign ps8_s11 = asr32(p10_r, 8);
  always_ff @(posedge clk) begin
    if (en) begin
      mm11_r <= ps8_s11 * ps8_s11;
      mx11_r <= P_K2 * p10_r;
      p11_r  <= p10_r;
      t11_r  <= t10_r;
      e11_r  <= e10_r;
    end
  end

  // Stage 12: scale the squared term.
  logic        s12_v_r, e12_r;
  logic [15:0] t12_r;
  logic [31:0] p12_r, m3_12_r, x2_12_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m3_12_r <= mm11_r * P_K1;
      x2_12_r <= asr32(mx11_r, 16);
      p12_r   <= p11_r;
      t12_r   <= t11_r;
      e12_r   <= e11_r;
    end
  end

  // Output register: final correction, saturation and error zeroing.
  logic [31:0] pf;
  logic [17:0] psat;
  always_comb begin
    pf = p12_r + asr32(asr32(m3_12_r, 16) + x2_12_r + P_K3, 4);
    if (pf[31])              psat = '0;
    else if (pf > PRESS_MAX) psat = PRESS_MAX[17:0];
    else                     psat = pf[17:0];
  end

  logic [15:0] temp_r;
  logic [17:0] press_r;
  logic        err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      temp_r  <= e12_r ? 16'd0 : t12_r;
      press_r <= e12_r ? 18'd0 : psat;
      err_r   <= e12_r;
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;  s2_v_r <= 1'b0;  s3_v_r <= 1'b0;  s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;  s6_v_r <= 1'b0;  s7_v_r <= 1'b0;  s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;  s10_v_r <= 1'b0; s11_v_r <= 1'b0; s12_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_if.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= d1_v;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= d2_v;
      s11_v_r <= s10_v_r;
      s12_v_r <= s11_v_r;
      out_valid_r <= s12_v_r;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.temperature_tenths = temp_r;
  assign out_if.pressure_pa        = press_r;
  assign out_if.divide_error       = err_r;

endmodule

/* sim/barometer_integer_compensation_core_tb.sv */
// Testbench for barometer_integer_compensation_core: random and directed readings
// are checked against a local integer compensation predictor.
// Depends on bic_pkg, the bic_in_if / bic_out_if interfaces and the core.
`timescale 1ns / 100ps

module barometer_integer_compensation_core_tb;
  import bic_pkg::*;

  typedef struct packed {
    logic [RAW_T_W-1:0] ut;
    logic [RAW_P_W-1:0] up;
  } raw_reading_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [PRESS_W-1:0] press;
    logic               div_err;
  } comp_reading_t;

  localparam int IDLE_WAIT  = 100;
  localparam int WDOG_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  bic_in_if  in_if ();
  bic_out_if out_if ();

  barometer_integer_compensation_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #4 clk = ~clk;

  // Local copy of the configuration registers.
  logic [1:0]  oss_cfg = '0;
  logic [63:0] cal_a = '0;
  logic [63:0] cal_b = '0;
  logic [31:0] cal_c = '0;

  raw_reading_t  pending_q[$];
  comp_reading_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_div_err = 0;
  int n_phases = 0;
  bit long_hold_done = 1'b0;
  bit in_acc = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_pressure = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [31:0] sar(input logic [31:0] v, input int n);
    sar = $signed(v) >>> n;
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    sext = {{16{v[15]}}, v};
  endfunction

  // Signed division that truncates toward zero.
  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    sdiv = (a[31] != b[31]) ? -q : q;
  endfunction

  // Integer compensation of one raw reading under the current calibration.
  function automatic comp_reading_t compensate(input raw_reading_t r);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, d, b5, b6, b3, b4, b7, p, sq, tt;
    comp_reading_t res;
    res = '{temp: '0, press: '0, div_err: 1'b1};
    ac1 = sext(cal_a[15:0]);  ac2 = sext(cal_a[31:16]);
    ac3 = sext(cal_a[47:32]); ac4 = {16'b0, cal_a[63:48]};
    ac5 = {16'b0, cal_b[15:0]}; ac6 = {16'b0, cal_b[31:16]};
    b1 = sext(cal_b[47:32]);  b2 = sext(cal_b[63:48]);
    mc = sext(cal_c[15:0]);   md = sext(cal_c[31:16]);
    ut = {16'b0, r.ut};
    up = {13'b0, r.up};

    // Temperature path.
    x1 = sar((ut - ac6) * ac5, 15);
    d = x1 + md;
    if (d == 0) return res;
    x2 = sdiv(mc << 11, d);
    b5 = x1 + x2;
    tt = sar(b5 + 32'd8, 4);
    if ($signed(tt) > 32767) res.temp = 16'h7FFF;
    else if ($signed(tt) < -32768) res.temp = 16'h8000;
    else res.temp = tt[15:0];

    // Pressure coefficients.
    b6 = b5 - 32'd4000;
    sq = sar(b6 * b6, 12);
    x1 = sar(b2 * sq, 11);
    x2 = sar(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sar(((ac1 * 32'd4 + x3) << oss_cfg) + 32'd2, 2);
    x1 = sar(ac3 * b6, 13);
    x2 = sar(b1 * sq, 16);
    x3 = sar(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      res.temp = '0;
      return res;
    end

    // Two-path division and the final correction.
    b7 = (up - b3) * (32'd50000 >> oss_cfg);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sar(p, 8);
    x1 = x1 * x1;
    x1 = sar(x1 * 32'd3038, 16);
    x2 = sar(32'hFFFF_E343 * p, 16);
    p = p + sar(x1 + x2 + 32'd3791, 4);
    if ($signed(p) < 0) res.press = '0;
    else if ($signed(p) > 262143) res.press = 18'h3FFFF;
    else res.press = p[17:0];
    res.div_err = 1'b0;
    return res;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  // A request that is still waiting stays on the bus unchanged.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!(in_if.valid && !in_acc)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.raw_temperature <= pending_q[0].ut;
        in_if.raw_pressure <= pending_q[0].up;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Accepted requests get their expected result.
  always @(posedge clk) begin
    in_acc = rst_n && in_if.valid && in_if.ready;
    if (in_acc) begin
      expected_q.push_back(compensate(pending_q[0]));
      void'(pending_q.pop_front());
      n_sent++;
    end
  end

  // Receiver: random stall pattern, plus one long hold-off.
  int hold_left = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (!long_hold_done && n_checked >= 150) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    comp_reading_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result t=%0h p=%0h e=%0b", $time,
                 out_if.temperature_tenths, out_if.pressure_pa, out_if.divide_error);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.temperature_tenths !== exp_r.temp) begin
          $display("%0t: temperature expected %0h actual %0h", $time, exp_r.temp,
                   out_if.temperature_tenths);
          errors++;
        end
        if (out_if.pressure_pa !== exp_r.press) begin
          $display("%0t: pressure expected %0h actual %0h", $time, exp_r.press,
                   out_if.pressure_pa);
          errors++;
        end
        if (out_if.divide_error !== exp_r.div_err) begin
          $display("%0t: divide error expected %0b actual %0b", $time, exp_r.div_err,
                   out_if.divide_error);
          errors++;
        end
        if (exp_r.div_err) n_div_err++;
      end
      n_checked++;
    end
  end

  // Watchdog on cycles with no accepted request on either channel and no configuration access.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_OSS:   oss_cfg = val[1:0];
      REG_CAL_A: cal_a = val;
      REG_CAL_B: cal_b = val;
      default:   cal_c = val[31:0];
    endcase
  endtask

  task automatic set_cal(input logic [1:0] oss, input logic [63:0] a, input logic [63:0] b,
                         input logic [31:0] c);
    cfg_write(REG_OSS, {62'b0, oss});
    cfg_write(REG_CAL_A, a);
    cfg_write(REG_CAL_B, b);
    cfg_write(REG_CAL_C, {32'b0, c});
    n_phases++;
  endtask

  task automatic queue_reading(input logic [15:0] ut, input logic [18:0] up);
    raw_reading_t r;
    r.ut = ut;
    r.up = up;
    pending_q.push_back(r);
  endtask

  // Random readings: mostly in the range for the current oversampling.
  task automatic queue_random(input int count);
    logic [18:0] up;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) up = 19'($urandom_range(0, 19'h7FFFF));
      else up = 19'($urandom_range(0, (1 << (16 + oss_cfg)) - 1));
      queue_reading(16'($urandom_range(0, 16'hFFFF)), up);
    end
  endtask

  // Let all results drain, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Typical calibration, packed into the register words.
  localparam logic [63:0] TYP_A = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
  localparam logic [63:0] TYP_B = {16'd4, 16'd6190, 16'd23153, 16'd32757};
  localparam logic [31:0] TYP_C = {16'd2868, 16'hDDF9};

  initial begin
    logic [63:0] ra, rb;
    logic [31:0] rc;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: the temperature divisor is zero.
    queue_reading(16'h0000, 19'h00000);
    queue_reading(16'hFFFF, 19'h7FFFF);
    wait_idle();

    // Typical calibration, field extremes and every oversampling setting.
    for (int o = 0; o < 4; o++) begin
      set_cal(o[1:0], TYP_A, TYP_B, TYP_C);
      queue_reading(16'd27898, 19'd23843 << o);
      queue_reading(16'h0000, 19'h00000);
      queue_reading(16'hFFFF, 19'h7FFFF);
      queue_reading(16'h8000, 19'h40000);
      wait_idle();
    end

    // Zero pressure divisor: ac4 cleared.
    set_cal(2'd0, {16'd0, TYP_A[47:0]}, TYP_B, TYP_C);
    queue_reading(16'd27898, 19'd23843);
    queue_reading(16'h1234, 19'h0ABCD);
    wait_idle();

    // Zero temperature divisor with a nonzero mc, and all-ones registers.
    set_cal(2'd1, TYP_A, {TYP_B[63:16], 16'd0}, {16'd0, 16'h1234});
    queue_reading(16'd30000, 19'd40000);
    wait_idle();
    set_cal(2'd3, '1, '1, '1);
    queue_reading(16'hFFFF, 19'h7FFFF);
    queue_reading(16'h0000, 19'h00000);
    queue_reading(16'h7FFF, 19'h12345);
    wait_idle();

    // Random phases: perturbed typical calibration or fully random words.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) begin
        ra = {$urandom, $urandom};
        rb = {$urandom, $urandom};
        rc = $urandom;
      end else begin
        ra = TYP_A ^ {16'($urandom_range(0, 16'h0FFF)), 16'($urandom_range(0, 16'h03FF)),
                      16'($urandom_range(0, 16'h00FF)), 16'($urandom_range(0, 16'h00FF))};
        rb = TYP_B ^ {16'($urandom_range(0, 16'h000F)), 16'($urandom_range(0, 16'h03FF)),
                      16'($urandom_range(0, 16'h0FFF)), 16'($urandom_range(0, 16'h0FFF))};
        rc = TYP_C ^ {16'($urandom_range(0, 16'h01FF)), 16'($urandom_range(0, 16'h01FF))};
      end
      set_cal(2'($urandom_range(0, 3)), ra, rb, rc);
      queue_random(60);
      wait_idle();
    end

    $display("Checked %0d readings over %0d calibration settings, %0d with divide error.",
             n_checked, n_phases, n_div_err);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
